FILE: rtl/score_window_statistics_assert.svh
// Assertion helpers shared by the score window statistics RTL.
`ifndef SCORE_WINDOW_STATISTICS_ASSERT_SVH
`define SCORE_WINDOW_STATISTICS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sws_pkg.sv
`default_nettype none

package sws_pkg;

  // Fixed field and accumulator widths
  localparam int SCORE_W = 16;
  localparam int TOTAL_W = 48;
  localparam int COUNT_W = 32;
  localparam int FILL_OUT_W = 4;

  // Divider geometry: dividend, divisor, step counter
  localparam int DIV_W = 48;
  localparam int DVR_W = 32;
  localparam int STEP_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [SCORE_W-1:0] BEST_RST = 16'sh8000;

  // Request to the divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DVR_W-1:0]  divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: rtl/sws_ram.sv
`default_nettype none

module sws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sws_div.sv
`default_nettype none
`include "score_window_statistics_assert.svh"

// Unsigned restoring divider, one quotient bit per cycle.
// The dividend must sit at the top of the register; after N steps the low
// N bits hold the quotient.
module sws_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sws_pkg::div_req_t           req,
  output logic                             busy,
  output logic [sws_pkg::DIV_W-1:0]        quotient
);

  logic                          busy_r, busy_nxt;
  logic [sws_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [sws_pkg::DVR_W-1:0]     rem_r, rem_nxt;
  logic [sws_pkg::DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [sws_pkg::DVR_W-1:0]     dvr_r, dvr_nxt;
  logic [sws_pkg::DVR_W:0]       rem_sh;
  logic [sws_pkg::DVR_W+1:0]     diff;
  logic                          fits;

  // Trial subtract
  assign rem_sh = {rem_r, dvd_r[sws_pkg::DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvr_r};
  assign fits   = !diff[sws_pkg::DVR_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvr_nxt  = dvr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[sws_pkg::DVR_W-1:0] : rem_sh[sws_pkg::DVR_W-1:0];
      dvd_nxt = {dvd_r[sws_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == sws_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvr_r <= dvr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

  `SWS_ASSERT_IMP(a_no_start_busy, clk, rst_n, req.start, !busy_r, "divider restarted while busy")
  `SWS_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_r, "divider did not start")

endmodule

`default_nettype wire

FILE: rtl/score_window_statistics.sv
`default_nettype none
`include "score_window_statistics_assert.svh"

// Score window statistics: one signed Q8.8 score per input beat, one result
// beat per score carrying the best score so far, the mean of all counted
// scores, the mean of the last WINDOW scores, a novice flag (window not yet
// full) and the window fill. Both means truncate toward zero; the score
// count saturates at 2^32-1, after which count and total hold. One score is
// in flight at a time. Its result is registered into the output once the
// bit-serial divider has run over the 48-bit total and then over the
// SUM_W-bit window sum, SUM_W = 16 + clog2(WINDOW+1), and the next score can
// be taken while that result is presented. The window ring lives in a
// one-port-read RAM read at acceptance, its data used the next cycle; no
// clearing pass is needed after reset. A finished result waits in the output
// register while the next score is accepted; a result still stalled there
// when the next one is done holds the block until it leaves.
module score_window_statistics #(
  parameter int WINDOW = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sws_pkg::SCORE_W-1:0]  in_score,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [sws_pkg::SCORE_W-1:0]       out_best,
  output logic signed [sws_pkg::SCORE_W-1:0]       out_overall_mean,
  output logic signed [sws_pkg::SCORE_W-1:0]       out_recent_mean,
  output logic                                     out_is_novice,
  output logic [sws_pkg::FILL_OUT_W-1:0]           out_window_fill
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int SUM_W = sws_pkg::SCORE_W + $clog2(WINDOW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OLD  = 2'd1;
  localparam logic [1:0] S_DIV1 = 2'd2;
  localparam logic [1:0] S_DIV2 = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic signed [sws_pkg::SCORE_W-1:0]  score_r, score_nxt;
  logic [sws_pkg::COUNT_W-1:0]         count_r, count_nxt;
  logic signed [sws_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic signed [sws_pkg::SCORE_W-1:0]  best_r, best_nxt;
  logic [AW-1:0]                       head_r, head_nxt;
  logic [FW-1:0]                       fill_r, fill_nxt;
  logic signed [SUM_W-1:0]             wsum_r, wsum_nxt;
  logic [sws_pkg::SCORE_W-1:0]         overall_r, overall_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [sws_pkg::SCORE_W-1:0]  out_best_r, out_best_nxt;
  logic signed [sws_pkg::SCORE_W-1:0]  out_overall_r, out_overall_nxt;
  logic signed [sws_pkg::SCORE_W-1:0]  out_recent_r, out_recent_nxt;
  logic                                out_novice_r, out_novice_nxt;
  logic [sws_pkg::FILL_OUT_W-1:0]      out_fill_r, out_fill_nxt;

  logic                                in_accept;
  logic                                count_sat;
  logic [sws_pkg::COUNT_W-1:0]         count_inc;
  logic                                full;
  logic [sws_pkg::TOTAL_W-1:0]         total_mag;
  logic [SUM_W-1:0]                    wsum_mag;
  logic [FW+sws_pkg::FILL_OUT_W-1:0]   fill_ext;

  logic                                ram_we, ram_re;
  logic [sws_pkg::SCORE_W-1:0]         ram_rdata;

  sws_pkg::div_req_t                   div_req;
  logic                                div_busy;
  logic [sws_pkg::DIV_W-1:0]           div_q;

  // Window ring
  sws_ram #(
    .WIDTH (sws_pkg::SCORE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (score_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Shared divider for both means
  sws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign count_sat = (count_r == sws_pkg::COUNT_MAX);
  assign count_inc = count_sat ? count_r : count_r + 1'b1;
  assign full      = (fill_r == FW'(WINDOW));
  assign total_mag = total_r[sws_pkg::TOTAL_W-1] ? -total_r : total_r;
  assign wsum_mag  = wsum_r[SUM_W-1] ? -wsum_r : wsum_r;
  assign fill_ext  = {{sws_pkg::FILL_OUT_W{1'b0}}, fill_r};

  // Sequencer: accept, read old slot, overall mean, recent mean
  always_comb begin
    state_nxt       = state_r;
    score_nxt       = score_r;
    count_nxt       = count_r;
    total_nxt       = total_r;
    best_nxt        = best_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    wsum_nxt        = wsum_r;
    overall_nxt     = overall_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_best_nxt    = out_best_r;
    out_overall_nxt = out_overall_r;
    out_recent_nxt  = out_recent_r;
    out_novice_nxt  = out_novice_r;
    out_fill_nxt    = out_fill_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    div_req         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          score_nxt = in_score;
          count_nxt = count_inc;
          if (!count_sat) begin
            total_nxt = total_r + sws_pkg::TOTAL_W'(in_score);
          end
          if (count_inc == sws_pkg::COUNT_W'(1) || in_score > best_r) begin
            best_nxt = in_score;
          end
          ram_re    = 1'b1;
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        // old slot data is valid now; drop it only when the window is full
        wsum_nxt = wsum_r + SUM_W'(score_r)
                   - (full ? SUM_W'($signed(ram_rdata)) : SUM_W'(0));
        if (!full) begin
          fill_nxt = fill_r + 1'b1;
        end
        ram_we   = 1'b1;
        head_nxt = (head_r == AW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
        div_req.start    = 1'b1;
        div_req.steps    = sws_pkg::STEP_W'(sws_pkg::DIV_W);
        div_req.dividend = total_mag;
        div_req.divisor  = count_r;
        state_nxt        = S_DIV1;
      end
      S_DIV1: begin
        if (!div_busy) begin
          overall_nxt = total_r[sws_pkg::TOTAL_W-1] ? -div_q[sws_pkg::SCORE_W-1:0]
                                                     : div_q[sws_pkg::SCORE_W-1:0];
          div_req.start    = 1'b1;
          div_req.steps    = sws_pkg::STEP_W'(SUM_W);
          div_req.dividend = {wsum_mag, {(sws_pkg::DIV_W - SUM_W){1'b0}}};
          div_req.divisor  = sws_pkg::DVR_W'(fill_r);
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!div_busy && (!out_valid_r || !out_stall)) begin
          out_valid_nxt   = 1'b1;
          out_best_nxt    = best_r;
          out_overall_nxt = overall_r;
          out_recent_nxt  = wsum_r[SUM_W-1] ? -div_q[sws_pkg::SCORE_W-1:0]
                                            : div_q[sws_pkg::SCORE_W-1:0];
          out_novice_nxt  = (fill_r < FW'(WINDOW));
          out_fill_nxt    = fill_ext[sws_pkg::FILL_OUT_W-1:0];
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      best_r      <= sws_pkg::BEST_RST;
      head_r      <= '0;
      fill_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      best_r      <= best_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    score_r       <= score_nxt;
    overall_r     <= overall_nxt;
    out_best_r    <= out_best_nxt;
    out_overall_r <= out_overall_nxt;
    out_recent_r  <= out_recent_nxt;
    out_novice_r  <= out_novice_nxt;
    out_fill_r    <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_best         = out_best_r;
  assign out_overall_mean = out_overall_r;
  assign out_recent_mean  = out_recent_r;
  assign out_is_novice    = out_novice_r;
  assign out_window_fill  = out_fill_r;

  // Until the ring wraps the head tracks the fill count
  `SWS_ASSERT_IMP(a_head_fill, clk, rst_n, !full, head_r == fill_r[AW-1:0], "ring head lost fill")
  // A result appears only out of the recent-mean step
  `SWS_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DIV2, "stray result")
  // An accepted beat always starts the old-slot read
  `SWS_ASSERT_NXT(a_acc_read, clk, rst_n, in_accept, state_r == S_OLD, "accept not sequenced")

endmodule

`default_nettype wire
